// ===== rtl/sorted_integer_list_assert.svh =====
// Assertion macros for the sorted integer list RTL.
// Included by files that check their own logic; needs nothing else.
`ifndef SORTED_INTEGER_LIST_ASSERT_SVH
`define SORTED_INTEGER_LIST_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SIL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SIL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sil_pkg.sv =====
// Shared types and constants of the sorted integer list.
// Used by sil_cell, sorted_integer_list and the testbench; depends on nothing.
package sil_pkg;

    // Sizes of the list and of the item fields.
    localparam int DEPTH = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // Per-cell shift control for one operation.
    typedef struct packed {
        logic ins_en;     // insert shift is active this cycle
        logic take_next;  // cell copies its right-hand neighbour (remove)
    } cell_ctrl_t;

    // Number of ones in a low-aligned thermometer code, found from its edge.
    function automatic logic [CNT_W-1:0] therm_count(input logic [DEPTH-1:0] t);
        logic [CNT_W-1:0] res;
        logic             upper;
        res = '0;
        for (int i = 0; i < DEPTH; i++) begin
            upper = (i == DEPTH - 1) ? 1'b0 : t[(i + 1) % DEPTH];
            if (t[i] && !upper) begin
                res = res | CNT_W'(i + 1);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/sorted_integer_list.sv =====
// Top level of the sorted integer list: a row of sil_cell entries with
// the item, decode and result stages around it. Depends on sil_pkg,
// sil_cell and sorted_integer_list_assert.svh.
//
// The list keeps up to 32 signed 32-bit entries in ascending order in a row
// of cells. Every cell compares its entry with the item in the same cycle,
// so insert, read, count, find and remove each complete within the cell row
// stage, and the block sustains one transfer per clock while m_axis_tready
// is high. An item passes three registers: the input register, the cell
// row stage and the result register, and the master-side tvalid rises once
// the item has reached the result register. The input side keeps accepting
// while a result waits, until the three stages are full. Entries are not
// cleared at reset; only the entry count is, so the block is ready as soon
// as reset is released.
`include "sorted_integer_list_assert.svh"

module sorted_integer_list
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_value[31:0], position[36:32], zero
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // read_value[31:0], match_count[37:32],
                                       // match_position[42:38], entries_held[48:43],
                                       // zero
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int DEPTH = sil_pkg::DEPTH;
    localparam int VAL_W = sil_pkg::VAL_W;
    localparam int POS_W = sil_pkg::POS_W;
    localparam int CNT_W = sil_pkg::CNT_W;
    localparam int OP_W  = sil_pkg::OP_W;
    localparam int ST_W  = sil_pkg::ST_W;

    // Input stage
    logic                    item_valid_reg;
    logic [OP_W-1:0]         item_op_reg;
    logic signed [VAL_W-1:0] item_value_reg;
    logic [POS_W-1:0]        item_pos_reg;

    // Cell row stage
    logic                    mid_valid_reg;
    logic [OP_W-1:0]         mid_op_reg;
    logic                    mid_fail_reg;
    logic signed [VAL_W-1:0] mid_rd_reg;
    logic [CNT_W-1:0]        mid_lt_cnt_reg;
    logic [CNT_W-1:0]        mid_le_cnt_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // Result stage
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_rd_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic [POS_W-1:0]        out_mpos_reg;
    logic [ST_W-1:0]         out_st_reg;
    logic [CNT_W-1:0]        out_held_reg;
    logic [CNT_W-1:0]        out_held_q_reg;
    logic signed [VAL_W-1:0] out_rd_next;
    logic [CNT_W-1:0]        out_cnt_next;
    logic [POS_W-1:0]        out_mpos_next;
    logic [ST_W-1:0]         out_st_next;

    // Cell row wiring
    logic signed [VAL_W-1:0] entry_bus [DEPTH];
    logic [DEPTH-1:0]        lt_vec;
    logic [DEPTH-1:0]        le_vec;
    logic [DEPTH-1:0]        live_vec;
    sil_pkg::cell_ctrl_t     ctrl_vec [DEPTH];

    // Handshake and stage movement
    logic out_move;
    logic mid_move;
    logic exec_fire;
    logic in_fire;
    logic is_full;
    logic pos_beyond_count;
    logic ins_en;
    logic rem_en;

    assign out_move      = mid_valid_reg && (!out_valid_reg || m_axis_tready);
    assign mid_move      = out_move;
    assign exec_fire     = item_valid_reg && (!mid_valid_reg || mid_move);
    assign s_axis_tready = !item_valid_reg || exec_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Operation checks against the current entry count.
    assign is_full          = (count_reg == CNT_W'(DEPTH));
    assign pos_beyond_count = ({1'b0, item_pos_reg} >= count_reg);
    assign ins_en = exec_fire && (item_op_reg == sil_pkg::OP_INSERT) && !is_full;
    assign rem_en = exec_fire && (item_op_reg == sil_pkg::OP_REMOVE) && !pos_beyond_count;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_op_reg    <= s_axis_tuser;
            item_value_reg <= s_axis_tdata[VAL_W-1:0];
            item_pos_reg   <= s_axis_tdata[VAL_W+POS_W-1:VAL_W];
        end
    end

    // Row of cells, each linked to its neighbours.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] prev_entry;
        logic                    prev_lt;
        logic signed [VAL_W-1:0] next_entry;

        assign live_vec[i]           = (CNT_W'(i) < count_reg);
        assign ctrl_vec[i].ins_en    = ins_en;
        assign ctrl_vec[i].take_next = rem_en && (CNT_W'(i) >= {1'b0, item_pos_reg});

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_inner
            assign prev_entry = entry_bus[i-1];
            assign prev_lt    = lt_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_entry = entry_bus[i];
        end
        else
        begin : g_body
            assign next_entry = entry_bus[i+1];
        end

        sil_cell u_cell
        (
            .clk        (clk),
            .live       (live_vec[i]),
            .item_value (item_value_reg),
            .ctrl       (ctrl_vec[i]),
            .prev_entry (prev_entry),
            .prev_lt    (prev_lt),
            .next_entry (next_entry),
            .entry      (entry_bus[i]),
            .lt         (lt_vec[i]),
            .le         (le_vec[i])
        );
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (exec_fire)
            begin
                mid_valid_reg <= 1'b1;
            end
            else if (mid_move)
            begin
                mid_valid_reg <= 1'b0;
            end
        end
    end

    // Cell row results: the compare flags form thermometer codes because the
    // entries are sorted, so their edges give the boundary positions.
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            mid_op_reg     <= item_op_reg;
            mid_rd_reg     <= entry_bus[item_pos_reg];
            mid_lt_cnt_reg <= sil_pkg::therm_count(lt_vec);
            mid_le_cnt_reg <= sil_pkg::therm_count(le_vec);
            mid_fail_reg   <= (item_op_reg == sil_pkg::OP_INSERT) ? is_full : pos_beyond_count;
            out_held_reg   <= count_next;
        end
    end

    // Result formatting per operation.
    always_comb
    begin
        out_rd_next   = '0;
        out_cnt_next  = '0;
        out_mpos_next = '0;
        out_st_next   = sil_pkg::ST_OK;
        unique case (mid_op_reg)
            sil_pkg::OP_INSERT:
            begin
                if (mid_fail_reg)
                begin
                    out_st_next = sil_pkg::ST_FULL;
                end
            end
            sil_pkg::OP_READ:
            begin
                if (mid_fail_reg)
                begin
                    out_st_next = sil_pkg::ST_RANGE;
                end
                else
                begin
                    out_rd_next = mid_rd_reg;
                end
            end
            sil_pkg::OP_COUNT:
            begin
                out_cnt_next = mid_le_cnt_reg - mid_lt_cnt_reg;
            end
            sil_pkg::OP_FIND:
            begin
                if (mid_le_cnt_reg != mid_lt_cnt_reg)
                begin
                    out_mpos_next = mid_lt_cnt_reg[POS_W-1:0];
                end
                else
                begin
                    out_st_next = sil_pkg::ST_NOTFOUND;
                end
            end
            sil_pkg::OP_REMOVE:
            begin
                if (mid_fail_reg)
                begin
                    out_st_next = sil_pkg::ST_RANGE;
                end
            end
            default:
            begin
                out_st_next = sil_pkg::ST_OK;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            out_rd_reg   <= out_rd_next;
            out_cnt_reg  <= out_cnt_next;
            out_mpos_reg <= out_mpos_next;
            out_st_reg   <= out_st_next;
        end
    end

    // The held count travels with the result; it is captured one stage early
    // and must follow the result into the output register.
    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            out_held_q_reg <= out_held_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_st_reg;
    assign m_axis_tdata  = {7'd0, out_held_q_reg, out_mpos_reg, out_cnt_reg, out_rd_reg};

    // The entry count never exceeds the number of cells.
    `SIL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count above depth")

    // An accepted insert into a list with room grows the count by one.
    `SIL_ASSERT_NEXT(a_insert_grows, clk, rst_n, ins_en, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the count")

    // Sorted entries make the less-than flags a single low-aligned run.
    `SIL_ASSERT_SAME(a_sorted_row, clk, rst_n, item_valid_reg, $onehot0(lt_vec ^ (lt_vec >> 1)), "cell row is not in ascending order")

    // A full status is only reported with every cell in use.
    `SIL_ASSERT_SAME(a_full_status, clk, rst_n, m_axis_tvalid && (m_axis_tuser == sil_pkg::ST_FULL), m_axis_tdata[48:43] == CNT_W'(DEPTH), "full status with free cells")

endmodule

// ===== rtl/sil_cell.sv =====
// One cell of the sorted list: holds one entry, compares it with the item
// and shifts it to or from its neighbours. Depends on sil_pkg.
module sil_cell
(
    input  logic                               clk,
    input  logic                               live,
    input  logic signed [sil_pkg::VAL_W-1:0]   item_value,
    input  sil_pkg::cell_ctrl_t                ctrl,
    input  logic signed [sil_pkg::VAL_W-1:0]   prev_entry,
    input  logic                               prev_lt,
    input  logic signed [sil_pkg::VAL_W-1:0]   next_entry,
    output logic signed [sil_pkg::VAL_W-1:0]   entry,
    output logic                               lt,
    output logic                               le
);

    logic signed [sil_pkg::VAL_W-1:0] entry_reg;
    logic signed [sil_pkg::VAL_W-1:0] entry_next;

    // Signed comparisons against the item, masked to live entries.
    assign lt    = live && (entry_reg < item_value);
    assign le    = live && (entry_reg <= item_value);
    assign entry = entry_reg;

    // Shift selection: an insert pushes entries right from the first cell
    // not below the item; a remove pulls entries left from the position.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en) begin
            if (lt) begin
                entry_next = entry_reg;
            end else if (prev_lt) begin
                entry_next = item_value;
            end else begin
                entry_next = prev_entry;
            end
        end else if (ctrl.take_next) begin
            entry_next = next_entry;
        end
    end

    // Entry storage; contents are only meaningful while the cell is live.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_integer_list: drives list operations on the input stream
// and checks every result against a behavioural copy of the list. Depends on sil_pkg and the RTL.
module testbench;

    import sil_pkg::*;

    // One list operation as it travels on the input stream.
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } list_cmd_t;

    // One result as it travels on the output stream.
    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        match_count;
        logic [POS_W-1:0]        match_position;
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        entries_held;
    } list_result_t;

    // Operation mix of a stretch of random traffic.
    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} traffic_phase_t;

    localparam int RANDOM_ITEMS = 1330;
    localparam int MAX_GAP      = 13;
    localparam int TAIL_CYCLES  = 12;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata = '0;   // item_value[31:0], position[36:32], zero
    logic [2:0]       s_axis_tuser = '0;   // operation[2:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [55:0]      m_axis_tdata;        // read_value[31:0], match_count[37:32],
                                           // match_position[42:38], entries_held[48:43], zero
    logic [1:0]       m_axis_tuser;        // status[1:0]

    // Shadow copy of the list contents and fill level.
    logic signed [VAL_W-1:0] shadow_entries [DEPTH];
    int                      shadow_held = 0;

    list_cmd_t    pending_cmds [$];
    list_result_t list_results [$];
    list_cmd_t    cur_cmd = '0;

    int  issued_count = 0;
    int  accepted_count = 0;
    int  fail_count = 0;
    logic send_taken = 1'b0;
    logic recv_taken = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  send_burst = 0;
    int  recv_burst = 0;

    sorted_integer_list DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the result it should produce.
    function automatic list_result_t apply_list_op(input list_cmd_t c);
        list_result_t r;
        int           slot;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            OP_INSERT:
            begin
                if (shadow_held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // New value goes before the first entry not less than it.
                    slot = 0;
                    while (slot < shadow_held && $signed(shadow_entries[slot]) < $signed(c.value))
                        slot++;
                    for (int i = shadow_held; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[slot] = c.value;
                    shadow_held++;
                end
            end
            OP_READ:
            begin
                if (int'(c.pos) >= shadow_held)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow_entries[c.pos];
            end
            OP_COUNT:
            begin
                for (int i = 0; i < shadow_held; i++)
                    if (shadow_entries[i] == c.value)
                        r.match_count++;
            end
            OP_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (int i = shadow_held - 1; i >= 0; i--)
                begin
                    if (shadow_entries[i] == c.value)
                    begin
                        r.match_position = POS_W'(i);
                        r.status = ST_OK;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (int'(c.pos) >= shadow_held)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (int i = c.pos; i + 1 < shadow_held; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_held--;
                end
            end
            default:
            begin
                // Unused codes leave the list alone.
            end
        endcase
        r.entries_held = CNT_W'(shadow_held);
        return r;
    endfunction

    // Idle cycles before the next transfer; now and then a stretch with none at all.
    function automatic int draw_gap(inout int burst_left);
        int gap;
        if (burst_left == 0 && $urandom_range(0, 7) == 0)
            burst_left = $urandom_range(10, 40);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
        end
        return gap;
    endfunction

    function automatic list_cmd_t make_cmd(input logic [OP_W-1:0] op,
                                           input logic signed [VAL_W-1:0] value,
                                           input logic [POS_W-1:0] pos);
        list_cmd_t c;
        c.op = op;
        c.value = value;
        c.pos = pos;
        return c;
    endfunction

    // Random operation whose mix depends on the traffic phase; values often repeat.
    function automatic list_cmd_t random_cmd(input traffic_phase_t ph);
        list_cmd_t c;
        int        roll;
        int        ins_cut;
        int        rd_cut;
        int        cnt_cut;
        int        fnd_cut;
        case (ph)
            PH_FILL:
            begin
                ins_cut = 70; rd_cut = 78; cnt_cut = 85; fnd_cut = 92;
            end
            PH_CHURN:
            begin
                ins_cut = 35; rd_cut = 50; cnt_cut = 62; fnd_cut = 75;
            end
            default:
            begin
                ins_cut = 15; rd_cut = 30; cnt_cut = 40; fnd_cut = 50;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_cut)
            c.op = OP_INSERT;
        else if (roll < rd_cut)
            c.op = OP_READ;
        else if (roll < cnt_cut)
            c.op = OP_COUNT;
        else if (roll < fnd_cut)
            c.op = OP_FIND;
        else if (roll < 97)
            c.op = OP_REMOVE;
        else
            c.op = OP_W'($urandom_range(5, 7));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            c.value = 32'sh7FFF_FFFF;
        else if (roll == 1)
            c.value = 32'sh8000_0000;
        else if (roll < 5)
            c.value = VAL_W'($urandom_range(0, 6)) - 32'sd3;
        else
            c.value = $urandom;
        if (c.op == OP_REMOVE && $urandom_range(0, 1) == 1)
            c.pos = POS_W'($urandom_range(0, 3));
        else
            c.pos = POS_W'($urandom_range(0, DEPTH - 1));
        return c;
    endfunction

    task automatic queue_cmd(input list_cmd_t c);
        pending_cmds.push_back(c);
        issued_count++;
    endtask

    // Holds the caller until every queued operation has produced its result.
    task automatic wait_drained();
        while (accepted_count < issued_count || list_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Input driver: presents the next operation after its idle gap.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || send_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, cur_cmd.pos, cur_cmd.value};
                s_axis_tuser <= cur_cmd.op;
                send_gap <= draw_gap(send_burst);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls for a random time after each transfer.
    always @(negedge clk)
    begin
        if (rst_n && (!m_axis_tready || recv_taken))
        begin
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap <= draw_gap(recv_burst);
            end
        end
    end

    // Monitor: checks each result transfer, then predicts for each input transfer.
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_value = m_axis_tdata[31:0];
                got.match_count = m_axis_tdata[37:32];
                got.match_position = m_axis_tdata[42:38];
                got.entries_held = m_axis_tdata[48:43];
                got.status = m_axis_tuser;
                if (list_results.size() == 0)
                begin
                    $display("%0t ns: result with none expected, tdata %h, tuser %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = list_results.pop_front();
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("match_count", want.match_count, got.match_count);
                    check_field("match_position", want.match_position, got.match_position);
                    check_field("status", want.status, got.status);
                    check_field("entries_held", want.entries_held, got.entries_held);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                list_results.push_back(apply_list_op(cur_cmd));
                accepted_count++;
            end
        end
        send_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        recv_taken <= rst_n && m_axis_tvalid && m_axis_tready;
    end

    // Stimulus: directed cases, then phased random traffic, then the final verdict.
    initial
    begin
        traffic_phase_t ph;
        int             produced;
        int             phase_len;
        bit             paused;

        // Operations on the empty list.
        queue_cmd(make_cmd(OP_READ, 32'sd0, 5'd0));
        queue_cmd(make_cmd(OP_REMOVE, 32'sd0, 5'd0));
        queue_cmd(make_cmd(OP_FIND, -32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_COUNT, -32'sd1, 5'd0));
        // Extremes, zero, one and a duplicate minus one, then queries and removes on them.
        queue_cmd(make_cmd(OP_INSERT, 32'sh7FFF_FFFF, 5'd31));
        queue_cmd(make_cmd(OP_INSERT, 32'sh8000_0000, 5'd0));
        queue_cmd(make_cmd(OP_INSERT, 32'sd0, 5'd0));
        queue_cmd(make_cmd(OP_INSERT, -32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_INSERT, -32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_INSERT, 32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_COUNT, -32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_COUNT, 32'sd5, 5'd0));
        queue_cmd(make_cmd(OP_FIND, -32'sd1, 5'd0));
        queue_cmd(make_cmd(OP_FIND, 32'sh7FFF_FFFF, 5'd0));
        queue_cmd(make_cmd(OP_FIND, 32'sd5, 5'd0));
        queue_cmd(make_cmd(OP_READ, 32'sd0, 5'd0));
        queue_cmd(make_cmd(OP_READ, 32'sd0, 5'd5));
        queue_cmd(make_cmd(OP_READ, 32'sd0, 5'd6));
        queue_cmd(make_cmd(OP_READ, 32'sd0, 5'd31));
        queue_cmd(make_cmd(OP_REMOVE, 32'sd0, 5'd2));
        queue_cmd(make_cmd(OP_REMOVE, 32'sd0, 5'd31));
        queue_cmd(make_cmd(OP_REMOVE, 32'sd0, 5'd4));
        // Unused operation codes.
        queue_cmd(make_cmd(3'd5, -32'sd1, 5'd31));
        queue_cmd(make_cmd(3'd6, 32'sd0, 5'd0));
        queue_cmd(make_cmd(3'd7, -32'sd1, 5'd31));

        // Reset released on a falling clock edge, away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The sender holds back until the directed part has fully completed.
        wait_drained();
        @(posedge clk);

        produced = 0;
        paused = 1'b0;
        ph = PH_FILL;
        while (produced < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 120);
            for (int k = 0; k < phase_len && produced < RANDOM_ITEMS; k++)
            begin
                queue_cmd(random_cmd(ph));
                produced++;
            end
            case (ph)
                PH_FILL:  ph = PH_CHURN;
                PH_CHURN: ph = PH_DRAIN;
                default:  ph = PH_FILL;
            endcase
            if (!paused && produced >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                @(posedge clk);
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_integer_list.sv
tb/testbench.sv
